FILE: rtl/rgblab_pkg.sv
`default_nettype none

package rgblab_pkg;

  // Field and datapath widths
  localparam int CH_W    = 8;
  localparam int LIN_W   = 31;   // linear channel, Q30, up to 1.0
  localparam int COEF_W  = 24;
  localparam int MPR_W   = COEF_W + LIN_W;
  localparam int NUM_W   = 56;   // dividend into the constant divider
  localparam int DIV_W   = 24;
  localparam int RCP_W   = 48;
  localparam int QUO_W   = 32;   // XYZ ratio, Q30
  localparam int F_W     = 31;   // f() value, Q30, below 2.0
  localparam int ROOT_STEPS = F_W;
  localparam int FRAC    = 30;
  localparam int L_W     = 15;
  localparam int AB_W    = 16;

  // Pipeline depths
  localparam int CDIV_LAT = 4;
  localparam int LABF_LAT = 2 * ROOT_STEPS;
  localparam int PIPE_LAT = 3 + CDIV_LAT + LABF_LAT + 2;

  // RGB to XYZ matrix, scaled by 10^7
  localparam logic [COEF_W-1:0] M_XR = 24'd4124564;
  localparam logic [COEF_W-1:0] M_XG = 24'd3575761;
  localparam logic [COEF_W-1:0] M_XB = 24'd1804375;
  localparam logic [COEF_W-1:0] M_YR = 24'd2126729;
  localparam logic [COEF_W-1:0] M_YG = 24'd7151522;
  localparam logic [COEF_W-1:0] M_YB = 24'd721750;
  localparam logic [COEF_W-1:0] M_ZR = 24'd193339;
  localparam logic [COEF_W-1:0] M_ZG = 24'd1191920;
  localparam logic [COEF_W-1:0] M_ZB = 24'd9503041;

  // White point divisors (scaled by 10^7) and their rounding offsets
  localparam logic [63:0] DIV_X   = 64'd9504560;
  localparam logic [63:0] DIV_Y   = 64'd10000000;
  localparam logic [63:0] DIV_Z   = 64'd10887540;
  localparam logic [63:0] DIV_LIN = 64'd1160;
  localparam logic [63:0] HALF_X  = 64'd4752280;
  localparam logic [63:0] HALF_Y  = 64'd5000000;
  localparam logic [63:0] HALF_Z  = 64'd5443770;

  // Reciprocals: ceil(2^NUM_W / d)
  localparam logic [63:0] RCP_X   = ((64'd1 << NUM_W) + DIV_X - 64'd1) / DIV_X;
  localparam logic [63:0] RCP_Y   = ((64'd1 << NUM_W) + DIV_Y - 64'd1) / DIV_Y;
  localparam logic [63:0] RCP_Z   = ((64'd1 << NUM_W) + DIV_Z - 64'd1) / DIV_Z;
  localparam logic [63:0] RCP_LIN = ((64'd1 << NUM_W) + DIV_LIN - 64'd1) / DIV_LIN;

  // Lab f(): cube root above this ratio, linear segment at or below
  localparam logic [63:0] CBRT_MIN = (64'd8856 << FRAC) / 64'd1000000;
  localparam logic [63:0] LIN_MUL  = 64'd9033;
  localparam logic [63:0] LIN_ADD  = (64'd160 << FRAC) + 64'd580;

  typedef logic [LIN_W-1:0] lin_t;
  typedef lin_t gamma_lut_t [256];

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << (FRAC - 1))) >> FRAC;
  endfunction

  // Gamma expansion of every byte, with the fifth root found by bit search
  function automatic gamma_lut_t build_gamma();
    gamma_lut_t lut;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] w;
    logic [63:0] y;
    logic [63:0] cand;
    logic [63:0] p;
    for (int i = 0; i < 256; i++) begin
      c = 64'(i);
      if (c * 64'd100000 <= 64'd1031475) begin
        lut[i] = LIN_W'((c * 64'd107374182400 + 64'd164730) / 64'd329460);
      end else begin
        v = (((c * 64'd1000 + 64'd14025) << FRAC) + 64'd134512) / 64'd269025;
        w = mul_q30(v, v);
        y = 64'd0;
        for (int k = FRAC; k >= 0; k--) begin
          cand = y | (64'd1 << k);
          if (cand <= (64'd1 << FRAC)) begin
            p = mul_q30(cand, cand);
            p = mul_q30(mul_q30(p, p), cand);
            if (p <= w) begin
              y = cand;
            end
          end
        end
        lut[i] = LIN_W'(mul_q30(w, y));
      end
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage

`default_nettype wire

FILE: rtl/rgb_to_cielab_converter.sv
// Channel   Handshake                  Beat
// pixel     pixel_valid / pixel_stall  red, green, blue, last_in
// lab       lab_valid / lab_stall      lightness, green_red_axis, blue_yellow_axis, last_out
//
// One pixel per clock is taken while pixel_stall is low; the pipeline depth
// is set by the 31-bit cube root (two stages per result bit).
// Reset (rst, synchronous) empties the pipeline and the output registers.
// A stall on lab parks one beat in a skid register; the pipeline then freezes
// and pixel_stall is raised until that beat moves into the output register.
`default_nettype none

module rgb_to_cielab_converter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [rgblab_pkg::CH_W-1:0]       red,
  input  logic [rgblab_pkg::CH_W-1:0]       green,
  input  logic [rgblab_pkg::CH_W-1:0]       blue,
  input  logic                              last_in,
  output logic                              lab_valid,
  input  logic                              lab_stall,
  output logic [rgblab_pkg::L_W-1:0]        lightness,
  output logic signed [rgblab_pkg::AB_W-1:0] green_red_axis,
  output logic signed [rgblab_pkg::AB_W-1:0] blue_yellow_axis,
  output logic                              last_out
);

  localparam int LW  = rgblab_pkg::LIN_W;
  localparam int MW  = rgblab_pkg::MPR_W;
  localparam int NW  = rgblab_pkg::NUM_W;
  localparam int QW  = rgblab_pkg::QUO_W;
  localparam int FW  = rgblab_pkg::F_W;
  localparam int LAT = rgblab_pkg::PIPE_LAT;
  localparam int LQ_W = 48;
  localparam int AQ_W = 52;
  localparam int RL_W = LQ_W - rgblab_pkg::FRAC;
  localparam int RA_W = AQ_W - rgblab_pkg::FRAC;
  localparam logic signed [LQ_W-1:0] L_OFS = LQ_W'(64'd4096 << rgblab_pkg::FRAC);
  localparam logic signed [LQ_W-1:0] L_HALF = LQ_W'(64'd1 << (rgblab_pkg::FRAC - 1));
  localparam logic signed [AQ_W-1:0] A_HALF = AQ_W'(64'd1 << (rgblab_pkg::FRAC - 1));
  localparam logic signed [RL_W-1:0] L_MAX = RL_W'(32767);
  localparam logic signed [RA_W-1:0] A_MAX = RA_W'(32767);
  localparam logic signed [RA_W-1:0] A_MIN = -RA_W'(32768);

  logic           en;
  logic [LAT-1:0] vpipe;
  logic [LAT-1:0] lpipe;

  logic [LW-1:0] lin_r, lin_g, lin_b;
  logic [MW-1:0] p_xr, p_xg, p_xb, p_yr, p_yg, p_yb, p_zr, p_zg, p_zb;
  logic [NW-1:0] n_x, n_y, n_z;
  logic [QW-1:0] t_x, t_y, t_z;
  logic [FW-1:0] f_x, f_y, f_z;

  logic signed [LQ_W-1:0] lq;
  logic signed [AQ_W-1:0] aq, bq;
  logic signed [RL_W-1:0] lr;
  logic signed [RA_W-1:0] ar, br;

  logic [rgblab_pkg::L_W-1:0]         l_fin;
  logic signed [rgblab_pkg::AB_W-1:0] a_fin, b_fin;

  logic                               skid_v;
  logic [rgblab_pkg::L_W-1:0]         skid_l;
  logic signed [rgblab_pkg::AB_W-1:0] skid_a, skid_b;
  logic                               skid_last;
  logic                               out_take;

  // Advance the whole pipeline unless a beat sits in the skid register
  assign en          = !skid_v;
  assign pixel_stall = skid_v;
  assign out_take    = lab_valid && !lab_stall;

  // Advance valid and last flags beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], pixel_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lpipe <= {lpipe[LAT-2:0], last_in};
    end
  end

  // Gamma-expand each channel by table, then form the matrix products
  always_ff @(posedge clk) begin
    if (en) begin
      lin_r <= rgblab_pkg::GAMMA_LUT[red];
      lin_g <= rgblab_pkg::GAMMA_LUT[green];
      lin_b <= rgblab_pkg::GAMMA_LUT[blue];
      p_xr  <= MW'(rgblab_pkg::M_XR) * MW'(lin_r);
      p_xg  <= MW'(rgblab_pkg::M_XG) * MW'(lin_g);
      p_xb  <= MW'(rgblab_pkg::M_XB) * MW'(lin_b);
      p_yr  <= MW'(rgblab_pkg::M_YR) * MW'(lin_r);
      p_yg  <= MW'(rgblab_pkg::M_YG) * MW'(lin_g);
      p_yb  <= MW'(rgblab_pkg::M_YB) * MW'(lin_b);
      p_zr  <= MW'(rgblab_pkg::M_ZR) * MW'(lin_r);
      p_zg  <= MW'(rgblab_pkg::M_ZG) * MW'(lin_g);
      p_zb  <= MW'(rgblab_pkg::M_ZB) * MW'(lin_b);
      n_x   <= NW'(p_xr) + NW'(p_xg) + NW'(p_xb) + NW'(rgblab_pkg::HALF_X);
      n_y   <= NW'(p_yr) + NW'(p_yg) + NW'(p_yb) + NW'(rgblab_pkg::HALF_Y);
      n_z   <= NW'(p_zr) + NW'(p_zg) + NW'(p_zb) + NW'(rgblab_pkg::HALF_Z);
    end
  end

  // Divide by the white point
  rgblab_cdiv u_div_x (
    .clk (clk), .en (en), .num (n_x),
    .div (rgblab_pkg::DIV_X[rgblab_pkg::DIV_W-1:0]),
    .rcp (rgblab_pkg::RCP_X[rgblab_pkg::RCP_W-1:0]),
    .quo (t_x)
  );

  rgblab_cdiv u_div_y (
    .clk (clk), .en (en), .num (n_y),
    .div (rgblab_pkg::DIV_Y[rgblab_pkg::DIV_W-1:0]),
    .rcp (rgblab_pkg::RCP_Y[rgblab_pkg::RCP_W-1:0]),
    .quo (t_y)
  );

  rgblab_cdiv u_div_z (
    .clk (clk), .en (en), .num (n_z),
    .div (rgblab_pkg::DIV_Z[rgblab_pkg::DIV_W-1:0]),
    .rcp (rgblab_pkg::RCP_Z[rgblab_pkg::RCP_W-1:0]),
    .quo (t_z)
  );

  rgblab_labf u_f_x (.clk (clk), .en (en), .t (t_x), .f (f_x));
  rgblab_labf u_f_y (.clk (clk), .en (en), .t (t_y), .f (f_y));
  rgblab_labf u_f_z (.clk (clk), .en (en), .t (t_z), .f (f_z));

  // Round half up and saturate
  always_comb begin
    lr = RL_W'((lq + L_HALF) >>> rgblab_pkg::FRAC);
    ar = RA_W'((aq + A_HALF) >>> rgblab_pkg::FRAC);
    br = RA_W'((bq + A_HALF) >>> rgblab_pkg::FRAC);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // scale the f() values into L*, a*, b*
      lq <= $signed(LQ_W'(f_y)) * $signed(LQ_W'(29696)) - L_OFS;
      aq <= $signed(AQ_W'(f_x) - AQ_W'(f_y)) * $signed(AQ_W'(128000));
      bq <= $signed(AQ_W'(f_y) - AQ_W'(f_z)) * $signed(AQ_W'(51200));
      if (lr < 0) begin
        l_fin <= '0;
      end else if (lr > L_MAX) begin
        l_fin <= rgblab_pkg::L_W'(L_MAX);
      end else begin
        l_fin <= rgblab_pkg::L_W'(lr);
      end
      a_fin <= (ar < A_MIN) ? rgblab_pkg::AB_W'(A_MIN) :
               (ar > A_MAX) ? rgblab_pkg::AB_W'(A_MAX) : rgblab_pkg::AB_W'(ar);
      b_fin <= (br < A_MIN) ? rgblab_pkg::AB_W'(A_MIN) :
               (br > A_MAX) ? rgblab_pkg::AB_W'(A_MAX) : rgblab_pkg::AB_W'(br);
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      lab_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_take || !lab_valid) begin
        lab_valid <= 1'b1;
        skid_v    <= 1'b0;
      end
    end else if (!lab_valid || out_take) begin
      lab_valid <= vpipe[LAT-1];
    end else if (vpipe[LAT-1]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_take || !lab_valid) begin
        lightness        <= skid_l;
        green_red_axis   <= skid_a;
        blue_yellow_axis <= skid_b;
        last_out         <= skid_last;
      end
    end else if (!lab_valid || out_take) begin
      lightness        <= l_fin;
      green_red_axis   <= a_fin;
      blue_yellow_axis <= b_fin;
      last_out         <= lpipe[LAT-1];
    end else begin
      skid_l    <= l_fin;
      skid_a    <= a_fin;
      skid_b    <= b_fin;
      skid_last <= lpipe[LAT-1];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rgblab_cdiv.sv
`default_nettype none

module rgblab_cdiv (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rgblab_pkg::NUM_W-1:0]  num,
  input  logic [rgblab_pkg::DIV_W-1:0]  div,
  input  logic [rgblab_pkg::RCP_W-1:0]  rcp,
  output logic [rgblab_pkg::QUO_W-1:0]  quo
);

  localparam int NW    = rgblab_pkg::NUM_W;
  localparam int RW    = rgblab_pkg::RCP_W;
  localparam int QW    = rgblab_pkg::QUO_W;
  localparam int NH    = NW / 2;
  localparam int RH    = RW / 2;
  localparam int PP_W  = (NW - NH) + (RW - RH);
  localparam int PRD_W = NW + RW;
  localparam int BK_W  = QW + rgblab_pkg::DIV_W;

  logic [NW-1:0]    n1;
  logic [NW-1:0]    n2;
  logic [NW-1:0]    n3;
  logic [PP_W-1:0]  pp_hh;
  logic [PP_W-1:0]  pp_hl;
  logic [PP_W-1:0]  pp_lh;
  logic [PP_W-1:0]  pp_ll;
  logic [PRD_W-1:0] prod;
  logic [QW-1:0]    est2;
  logic [QW-1:0]    est3;
  logic [BK_W-1:0]  back;

  // Sum the partial products of num times the reciprocal
  always_comb begin
    prod = (PRD_W'(pp_hh) << (NH + RH)) + (PRD_W'(pp_hl) << NH)
         + (PRD_W'(pp_lh) << RH) + PRD_W'(pp_ll);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // split the reciprocal product into four narrow multiplies
      n1    <= num;
      pp_hh <= PP_W'(num[NW-1:NH]) * PP_W'(rcp[RW-1:RH]);
      pp_hl <= PP_W'(num[NW-1:NH]) * PP_W'(rcp[RH-1:0]);
      pp_lh <= PP_W'(num[NH-1:0]) * PP_W'(rcp[RW-1:RH]);
      pp_ll <= PP_W'(num[NH-1:0]) * PP_W'(rcp[RH-1:0]);
      // estimate is the quotient or one above it
      n2    <= n1;
      est2  <= prod[NW +: QW];
      // multiply back
      n3    <= n2;
      est3  <= est2;
      back  <= BK_W'(est2) * BK_W'(div);
      // drop the estimate by one when it overshoots
      quo   <= (BK_W'(n3) < back) ? est3 - QW'(1) : est3;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rgblab_labf.sv
`default_nettype none

module rgblab_labf (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rgblab_pkg::QUO_W-1:0]  t,
  output logic [rgblab_pkg::F_W-1:0]    f
);

  localparam int FW      = rgblab_pkg::F_W;
  localparam int TW      = rgblab_pkg::QUO_W;
  localparam int NS      = rgblab_pkg::ROOT_STEPS;
  localparam int Y2_W    = 2 * FW;
  localparam int P_W     = FW + 2;
  localparam int FR      = rgblab_pkg::FRAC;
  localparam int LAT     = rgblab_pkg::LABF_LAT;
  localparam int LIN_DLY = LAT - 1 - rgblab_pkg::CDIV_LAT;

  logic [FW-1:0]   ry   [1:NS];
  logic [Y2_W-1:0] ry2  [1:NS];
  logic [TW-1:0]   rt   [1:NS];
  logic [FW-1:0]   cand_m [0:NS-1];
  logic [Y2_W-1:0] c2_m   [0:NS-1];
  logic [P_W-1:0]  p_m    [0:NS-1];
  logic [FW-1:0]   y_m    [0:NS-1];
  logic [Y2_W-1:0] y2_m   [0:NS-1];
  logic [TW-1:0]   t_m    [0:NS-1];

  logic [rgblab_pkg::NUM_W-1:0] lin_num;
  logic [TW-1:0]                lin_quo;
  logic [FW-1:0]                lin_dly [0:LIN_DLY-1];
  logic [LAT-1:0]               sel_dly;

  // Cube root: one result bit per two stages (square, then cube and compare)
  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam int B = FW - 1 - k;
    logic [FW-1:0]   yk;
    logic [Y2_W-1:0] y2k;
    logic [TW-1:0]   tk;
    logic [63:0]     sq;
    logic [63:0]     cube;

    if (k == 0) begin : g_first
      assign yk  = '0;
      assign y2k = '0;
      assign tk  = t;
    end else begin : g_next
      assign yk  = ry[k];
      assign y2k = ry2[k];
      assign tk  = rt[k];
    end

    // grow the exact square incrementally: (y + 2^B)^2
    assign sq = 64'(y2k) + (64'(yk) << (B + 1)) + (64'd1 << (2 * B));
    assign cube = ((64'(p_m[k]) * 64'(cand_m[k])) + (64'd1 << (FR - 1))) >> FR;

    always_ff @(posedge clk) begin
      if (en) begin
        cand_m[k] <= yk | (FW'(1) << B);
        c2_m[k]   <= Y2_W'(sq);
        p_m[k]    <= P_W'((sq + (64'd1 << (FR - 1))) >> FR);
        y_m[k]    <= yk;
        y2_m[k]   <= y2k;
        t_m[k]    <= tk;
      end
    end

    if (k < NS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          // keep the candidate bit when its cube stays at or below t
          rt[k+1] <= t_m[k];
          if (cube <= 64'(t_m[k])) begin
            ry[k+1]  <= cand_m[k];
            ry2[k+1] <= c2_m[k];
          end else begin
            ry[k+1]  <= y_m[k];
            ry2[k+1] <= y2_m[k];
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en) begin
          ry2[k+1] <= c2_m[k];
          rt[k+1]  <= t_m[k];
          ry[k+1]  <= (cube <= 64'(t_m[k])) ? cand_m[k] : y_m[k];
        end
      end
    end
  end

  // Linear segment: (903.3 t + 16) / 116 in Q30
  always_ff @(posedge clk) begin
    if (en) begin
      lin_num <= rgblab_pkg::NUM_W'(64'(t) * rgblab_pkg::LIN_MUL + rgblab_pkg::LIN_ADD);
    end
  end

  rgblab_cdiv u_lin_div (
    .clk (clk),
    .en  (en),
    .num (lin_num),
    .div (rgblab_pkg::DIV_LIN[rgblab_pkg::DIV_W-1:0]),
    .rcp (rgblab_pkg::RCP_LIN[rgblab_pkg::RCP_W-1:0]),
    .quo (lin_quo)
  );

  // Hold the linear result and the segment choice until the root is done
  always_ff @(posedge clk) begin
    if (en) begin
      lin_dly[0] <= lin_quo[FW-1:0];
      for (int i = 1; i < LIN_DLY; i++) begin
        lin_dly[i] <= lin_dly[i-1];
      end
      sel_dly <= {sel_dly[LAT-2:0], (64'(t) > rgblab_pkg::CBRT_MIN)};
    end
  end

  assign f = sel_dly[LAT-1] ? ry[NS] : lin_dly[LIN_DLY-1];

endmodule

`default_nettype wire

FILE: rtl/rgblab_checker.sv
`default_nettype none

module rgblab_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              pixel_valid,
  input logic                              pixel_stall,
  input logic                              lab_valid,
  input logic                              lab_stall,
  input logic [rgblab_pkg::L_W-1:0]        lightness,
  input logic signed [rgblab_pkg::AB_W-1:0] green_red_axis,
  input logic signed [rgblab_pkg::AB_W-1:0] blue_yellow_axis,
  input logic                              last_out
);

  // A stalled result beat stays offered
  assert property (@(posedge clk) disable iff (rst)
    lab_valid && lab_stall |=> lab_valid)
    else $error("lab beat dropped while stalled");

  // A stalled result beat keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    lab_valid && lab_stall |=> $stable(lightness) && $stable(green_red_axis)
      && $stable(blue_yellow_axis) && $stable(last_out))
    else $error("lab payload changed while stalled");

  // Input backpressure starts only after a stalled output beat
  assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_stall) |-> $past(lab_valid && lab_stall))
    else $error("pixel_stall rose without an output stall");

  // Input backpressure implies a full output register
  assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> lab_valid)
    else $error("pixel_stall with empty output");

endmodule

bind rgb_to_cielab_converter rgblab_checker u_rgblab_checker (.*);

`default_nettype wire
